// ===== rtl/hcr_pkg.sv =====
// hcr_pkg: shared types and constants of the configuration record converter
// holds parser phases, status codes and the command passed from front to back
// no dependencies
package hcr_pkg;

  // parser phase
  typedef enum logic [3:0] {
    PH_HEAD    = 4'd0,
    PH_ATYPE   = 4'd1,
    PH_CNT_HI  = 4'd2,
    PH_CNT_LO  = 4'd3,
    PH_NLEN_HI = 4'd4,
    PH_NLEN_LO = 4'd5,
    PH_NDATA   = 4'd6,
    PH_ABSORB  = 4'd7
  } hcr_phase_e;

  // done report status
  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FORMAT = 3'd1,
    ST_TRUNC  = 3'd2,
    ST_SIZE   = 3'd3,
    ST_FULL   = 3'd4
  } hcr_status_e;

  // configuration register index
  typedef enum logic {
    CFG_INPUT_LENGTH    = 1'b0,
    CFG_OUTPUT_CAPACITY = 1'b1
  } hcr_cfg_e;

  // result kind
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_DONE = 1'b1;

  // header layout
  localparam int unsigned HDR_LSIZE_POS = 21;
  localparam int unsigned HDR_NARR_POS  = 22;
  localparam logic [23:0] HDR_LEN       = 24'd23;
  localparam logic [23:0] MIN_LEN       = 24'd3;
  localparam logic [1:0]  LSIZE_MASK    = 2'b11;

  // start code bytes
  localparam logic [7:0] SC_ZERO = 8'h00;
  localparam logic [7:0] SC_ONE  = 8'h01;

  // depth of the command queue between front and back
  localparam int unsigned QDEPTH = 4;

  // work for the back part caused by one input byte
  typedef struct packed {
    logic        sc;      // emit 00 00 00 01
    logic        dat;     // emit the data byte
    logic        done;    // emit a done report after the bytes
    logic [7:0]  data;
    hcr_status_e status;
    logic [23:0] total;   // output count after this byte
    logic [2:0]  lsize;
  } hcr_cmd_t;

endpackage

// ===== rtl/hevc_config_record_to_annexb_top.sv =====
// hevc_config_record_to_annexb_top: configuration record to start-code stream
// joins the parser, the command queue and the result sequencer
// depends on hcr_pkg, hcr_front, hcr_queue, hcr_back
//
//   channel   direction  tdata / data                      tuser  tlast
//   s_axis    in         [7:0] data_byte                   -      -
//   m_axis    out        byte, status, total, length_size  kind   last
//   cfg       in         [23:0] register value, index 0/1  -      -
//
// one input byte is taken per cycle while the command queue has room
// the low byte of a nal length yields a done report alone, or four or five results,
// one per cycle from the output register while the receiver is ready
// the four-entry queue lets the parser run ahead during a burst
// reset clears all control state; no clearing pass is needed
module hevc_config_record_to_annexb_top #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  hcr_pkg::hcr_cfg_e  cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] data_byte
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  // [7:0] out_byte, [10:8] status, [34:11] total_out, [37:35] length_size
  output logic [39:0]        m_axis_tdata_o,
  output logic               m_axis_tuser_o,   // [0] kind
  output logic               m_axis_tlast_o
);
  import hcr_pkg::*;

  logic        cmd_valid, q_not_full, head_valid, pop;
  hcr_cmd_t    cmd, head_cmd;
  logic [7:0]  o_byte;
  logic [2:0]  o_status, o_lsize;
  logic [23:0] o_total;

  hcr_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_data_i   (s_axis_tdata_i),
    .in_ready_o  (s_axis_tready_o),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd),
    .cmd_ready_i (q_not_full)
  );

  hcr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (cmd_valid),
    .push_cmd_i   (cmd),
    .not_full_o   (q_not_full),
    .head_valid_o (head_valid),
    .head_cmd_o   (head_cmd),
    .pop_i        (pop)
  );

  hcr_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_valid_i    (head_valid),
    .q_cmd_i      (head_cmd),
    .q_pop_o      (pop),
    .out_valid_o  (m_axis_tvalid_o),
    .out_kind_o   (m_axis_tuser_o),
    .out_byte_o   (o_byte),
    .out_status_o (o_status),
    .out_total_o  (o_total),
    .out_lsize_o  (o_lsize),
    .out_last_o   (m_axis_tlast_o),
    .out_ready_i  (m_axis_tready_i)
  );

  // pack the result fields, lowest first
  assign m_axis_tdata_o = {2'b00, o_lsize, o_total, o_status, o_byte};

endmodule

// ===== rtl/hcr_front.sv =====
// hcr_front: configuration registers and the per-byte record parser
// classifies each input byte into at most one command for the back part
// depends on hcr_pkg
module hcr_front #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  hcr_pkg::hcr_cfg_e  cfg_idx_i,
  input  logic [23:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic [7:0]         in_data_i,
  output logic               in_ready_o,
  output logic               cmd_valid_o,
  output hcr_pkg::hcr_cmd_t  cmd_o,
  input  logic               cmd_ready_i
);
  import hcr_pkg::*;

  localparam int unsigned W = ((LENGTH_BITS > 24) ? LENGTH_BITS : 24) + 2;

  logic [23:0]            in_len_q, cap_q;
  hcr_phase_e             phase_q, phase_d;
  logic [LENGTH_BITS-1:0] pos_q, pos_d;
  logic [7:0]             arr_q, arr_d;
  logic [15:0]            nals_q, nals_d;
  logic [7:0]             held_q, held_d;
  logic [15:0]            nleft_q, nleft_d;
  logic [LENGTH_BITS-1:0] ocnt_q, ocnt_d;
  logic [1:0]             lz_q, lz_d;
  logic [2:0]             lsize_q, lsize_d;

  logic [W-1:0] pos_n, len_w, rem, cap_w, nal_w, need_w;
  logic [7:0]   arr_cur, sa_arr, sn_arr;
  logic [15:0]  nal_cur, nal_len, sn_nals;
  logic         sa_done, sn_done;
  hcr_status_e  sa_st, sn_st;
  hcr_phase_e   sa_ph, sn_ph;
  logic         accept;
  hcr_cmd_t     cmd;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_len_q <= HDR_LEN;
      cap_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_INPUT_LENGTH:    in_len_q <= cfg_wdata_i;
        CFG_OUTPUT_CAPACITY: cap_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // bytes still to come after this one
  assign pos_n  = {{(W-LENGTH_BITS){1'b0}}, pos_q} + W'(1);
  assign len_w  = {{(W-24){1'b0}}, in_len_q};
  assign cap_w  = {{(W-24){1'b0}}, cap_q};
  assign rem    = (pos_n <= len_w) ? (len_w - pos_n) : '0;
  assign nal_len = {held_q, in_data_i};
  assign nal_w  = {{(W-16){1'b0}}, nal_len};
  assign need_w = {{(W-LENGTH_BITS){1'b0}}, ocnt_q} + W'(4) + nal_w;

  // outcome of opening the next array
  always_comb begin
    arr_cur = (phase_q == PH_HEAD) ? in_data_i : arr_q;
    if (arr_cur == 8'd0) begin
      sa_done = 1'b1;
      sa_st   = ST_OK;
      sa_ph   = PH_ABSORB;
    end else if (rem < W'(3)) begin
      sa_done = 1'b1;
      sa_st   = ST_TRUNC;
      sa_ph   = PH_ABSORB;
    end else begin
      sa_done = 1'b0;
      sa_st   = ST_OK;
      sa_ph   = PH_ATYPE;
    end
    sa_arr = sa_done ? arr_cur : arr_cur - 8'd1;
  end

  // outcome of opening the next nal; the array count moves only when the nals run out
  always_comb begin
    nal_cur = (phase_q == PH_CNT_LO) ? nal_len : nals_q;
    sn_nals = nal_cur;
    sn_arr  = arr_q;
    if (nal_cur == 16'd0) begin
      sn_done = sa_done;
      sn_st   = sa_st;
      sn_ph   = sa_ph;
      sn_arr  = sa_arr;
    end else if (rem < W'(2)) begin
      sn_done = 1'b1;
      sn_st   = ST_TRUNC;
      sn_ph   = PH_ABSORB;
    end else begin
      sn_done = 1'b0;
      sn_st   = ST_OK;
      sn_ph   = PH_NLEN_HI;
      sn_nals = nal_cur - 16'd1;
    end
  end

  // per-byte parse step
  always_comb begin
    phase_d = phase_q;
    pos_d   = pos_q;
    arr_d   = arr_q;
    nals_d  = nals_q;
    held_d  = held_q;
    nleft_d = nleft_q;
    ocnt_d  = ocnt_q;
    lz_d    = lz_q;
    lsize_d = lsize_q;
    cmd     = '0;
    cmd.data   = in_data_i;
    cmd.status = ST_OK;

    case (phase_q)
      PH_HEAD: begin
        if (pos_q == '0) begin
          lz_d[0] = lz_q[0] | (in_data_i == 8'd0);
          if (in_len_q <= MIN_LEN) begin
            cmd.done = 1'b1; cmd.status = ST_FORMAT; phase_d = PH_ABSORB;
          end
        end else if (pos_q == LENGTH_BITS'(1)) begin
          lz_d[1] = lz_q[1] | (in_data_i == 8'd0);
        end else if (pos_q == LENGTH_BITS'(2)) begin
          if (lz_q == 2'b11 && in_data_i <= 8'd1) begin
            cmd.done = 1'b1; cmd.status = ST_FORMAT; phase_d = PH_ABSORB;
          end else if (in_len_q < HDR_LEN) begin
            cmd.done = 1'b1; cmd.status = ST_TRUNC; phase_d = PH_ABSORB;
          end
        end else if (pos_q == LENGTH_BITS'(HDR_LSIZE_POS)) begin
          lsize_d = {1'b0, in_data_i[1:0] & LSIZE_MASK} + 3'd1;
        end else if (pos_q == LENGTH_BITS'(HDR_NARR_POS)) begin
          arr_d      = sa_arr;
          phase_d    = sa_ph;
          cmd.done   = sa_done;
          cmd.status = sa_st;
        end
      end
      PH_ATYPE: phase_d = PH_CNT_HI;
      PH_CNT_HI: begin
        held_d  = in_data_i;
        phase_d = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        nals_d     = sn_nals;
        arr_d      = sn_arr;
        phase_d    = sn_ph;
        cmd.done   = sn_done;
        cmd.status = sn_st;
      end
      PH_NLEN_HI: begin
        held_d  = in_data_i;
        phase_d = PH_NLEN_LO;
      end
      PH_NLEN_LO: begin
        if (nal_w > rem) begin
          cmd.done = 1'b1; cmd.status = ST_SIZE; phase_d = PH_ABSORB;
        end else if (need_w > cap_w) begin
          cmd.done = 1'b1; cmd.status = ST_FULL; phase_d = PH_ABSORB;
        end else begin
          cmd.sc  = 1'b1;
          ocnt_d  = ocnt_q + LENGTH_BITS'(4);
          nleft_d = nal_len;
          if (nal_len == 16'd0) begin
            nals_d     = sn_nals;
            arr_d      = sn_arr;
            phase_d    = sn_ph;
            cmd.done   = sn_done;
            cmd.status = sn_st;
          end else begin
            phase_d = PH_NDATA;
          end
        end
      end
      PH_NDATA: begin
        cmd.dat = 1'b1;
        ocnt_d  = ocnt_q + LENGTH_BITS'(1);
        nleft_d = (nleft_q != 16'd0) ? nleft_q - 16'd1 : nleft_q;
        if (nleft_d == 16'd0) begin
          nals_d     = sn_nals;
          arr_d      = sn_arr;
          phase_d    = sn_ph;
          cmd.done   = sn_done;
          cmd.status = sn_st;
        end
      end
      PH_ABSORB: ;
      default: phase_d = PH_ABSORB;
    endcase

    cmd.total = 24'(ocnt_d);
    cmd.lsize = lsize_d;

    // record end: report a cut-short record, then restart
    if (pos_n >= len_w) begin
      if (phase_d != PH_ABSORB) begin
        cmd.done   = 1'b1;
        cmd.status = ST_TRUNC;
      end
      phase_d = PH_HEAD;
      pos_d   = '0;
      arr_d   = '0;
      nals_d  = '0;
      held_d  = '0;
      nleft_d = '0;
      ocnt_d  = '0;
      lz_d    = '0;
      lsize_d = '0;
    end else begin
      pos_d = pos_q + LENGTH_BITS'(1);
    end
  end

  assign accept      = in_valid_i && cmd_ready_i;
  assign in_ready_o  = cmd_ready_i;
  assign cmd_valid_o = accept && (cmd.sc || cmd.dat || cmd.done);
  assign cmd_o       = cmd;

  // parser state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HEAD;
      pos_q   <= '0;
      arr_q   <= '0;
      nals_q  <= '0;
      held_q  <= '0;
      nleft_q <= '0;
      ocnt_q  <= '0;
      lz_q    <= '0;
      lsize_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      arr_q   <= arr_d;
      nals_q  <= nals_d;
      held_q  <= held_d;
      nleft_q <= nleft_d;
      ocnt_q  <= ocnt_d;
      lz_q    <= lz_d;
      lsize_q <= lsize_d;
    end
  end

  // start code and data byte never come from the same input byte
  a_sc_xor_dat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_valid_o |-> !(cmd_o.sc && cmd_o.dat))
    else $error("start code and data byte in one command");

  // a done report leaves the parser absorbing or restarted
  a_done_absorb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_o && cmd_o.done) |=> (phase_q == PH_ABSORB || phase_q == PH_HEAD))
    else $error("parser still active after done report");

endmodule

// ===== rtl/hcr_queue.sv =====
// hcr_queue: short command queue between parser and result sequencer
// lets the parser keep taking bytes while a start code burst drains
// depends on hcr_pkg
module hcr_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  hcr_pkg::hcr_cmd_t push_cmd_i,
  output logic              not_full_o,
  output logic              head_valid_o,
  output hcr_pkg::hcr_cmd_t head_cmd_o,
  input  logic              pop_i
);
  import hcr_pkg::*;

  localparam int unsigned PW = $clog2(QDEPTH);

  hcr_cmd_t        mem_q [QDEPTH];
  logic [PW-1:0]   wr_q, rd_q;
  logic [PW:0]     cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign not_full_o   = (cnt_q != (PW+1)'(QDEPTH));
  assign head_valid_o = (cnt_q != '0);
  assign head_cmd_o   = mem_q[rd_q];
  assign do_push      = push_i && not_full_o;
  assign do_pop       = pop_i && head_valid_o;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) cnt_d = cnt_q + (PW+1)'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - (PW+1)'(1);
  end

  // pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) wr_q <= wr_q + PW'(1);
      if (do_pop)  rd_q <= rd_q + PW'(1);
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_q] <= push_cmd_i;
  end

  // occupancy stays within depth
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (PW+1)'(QDEPTH))
    else $error("command queue overflow");

endmodule

// ===== rtl/hcr_back.sv =====
// hcr_back: expands queued commands into result transfers, one per cycle
// while the output is accepted, and drives the registered output stream
// depends on hcr_pkg
module hcr_back #(
  parameter int unsigned LENGTH_BITS = 24
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  hcr_pkg::hcr_cmd_t q_cmd_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  output logic              out_kind_o,
  output logic [7:0]        out_byte_o,
  output logic [2:0]        out_status_o,
  output logic [23:0]       out_total_o,
  output logic [2:0]        out_lsize_o,
  output logic              out_last_o,
  input  logic              out_ready_i
);
  import hcr_pkg::*;

  localparam int unsigned OW = (LENGTH_BITS < 24) ? LENGTH_BITS : 24;
  localparam logic [23:0] TOT_MASK = 24'((64'd1 << OW) - 64'd1);

  logic [2:0]  sub_q, sub_d;
  logic [2:0]  n_res, offs;
  logic        load, is_last;
  logic        valid_q, kind_q, last_q;
  logic [7:0]  byte_q;
  logic [2:0]  status_q, lsize_q;
  logic [23:0] total_q;
  logic        kind_d;
  logic [7:0]  byte_d;
  logic [2:0]  status_d;
  logic [23:0] total_d;

  assign n_res   = (q_cmd_i.sc ? 3'd4 : 3'd0) + {2'b0, q_cmd_i.dat} + {2'b0, q_cmd_i.done};
  assign load    = q_valid_i && (!valid_q || out_ready_i);
  assign is_last = (sub_q == n_res - 3'd1);
  assign q_pop_o = load && is_last;
  assign offs    = 3'd3 - sub_q;

  // select the result at the current position of the command
  always_comb begin
    kind_d   = KIND_DONE;
    byte_d   = 8'h00;
    status_d = q_cmd_i.status;
    total_d  = q_cmd_i.total;
    if (q_cmd_i.sc && sub_q < 3'd4) begin
      kind_d   = KIND_BYTE;
      byte_d   = (sub_q == 3'd3) ? SC_ONE : SC_ZERO;
      status_d = ST_OK;
      total_d  = (q_cmd_i.total - {21'd0, offs}) & TOT_MASK;
    end else if (q_cmd_i.dat && sub_q == 3'd0) begin
      kind_d   = KIND_BYTE;
      byte_d   = q_cmd_i.data;
      status_d = ST_OK;
    end
  end

  always_comb begin
    sub_d = sub_q;
    if (load) sub_d = is_last ? 3'd0 : sub_q + 3'd1;
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      sub_q <= sub_d;
      if (load) valid_q <= 1'b1;
      else if (out_ready_i) valid_q <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      kind_q   <= kind_d;
      byte_q   <= byte_d;
      status_q <= status_d;
      total_q  <= total_d;
      lsize_q  <= q_cmd_i.lsize;
      last_q   <= is_last;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_kind_o   = kind_q;
  assign out_byte_o   = byte_q;
  assign out_status_o = status_q;
  assign out_total_o  = total_q;
  assign out_lsize_o  = lsize_q;
  assign out_last_o   = last_q;

  // a partly sent command stays at the queue head
  a_sub_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sub_q != 3'd0) |-> q_valid_i)
    else $error("command left the queue mid-burst");

  // a done report always closes its byte
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && kind_q == KIND_DONE) |-> last_q)
    else $error("done report not marked last");

endmodule

// ===== tb/tb_hevc_config_record_to_annexb_top.sv =====
// tb_hevc_config_record_to_annexb_top: self-checking bench for the record converter
// sends configuration records byte by byte and checks every stream byte and done report
// depends on hcr_pkg and hevc_config_record_to_annexb_top
module tb_hevc_config_record_to_annexb_top;
  import hcr_pkg::*;

  localparam int unsigned REC_ITEMS    = 300;
  localparam int unsigned DRAIN_CYCLES = 32;
  localparam int unsigned MAX_REPORTS  = 50;

  // one expected transfer on the master side
  typedef struct {
    logic        kind;
    logic [7:0]  obyte;
    logic [2:0]  status;
    logic [23:0] total;
    logic [2:0]  lsize;
    logic        last;
  } out_item_t;

  // directed stimulus row: a byte, a byte with a typed done report, or a register write
  typedef enum logic [1:0] {OP_BYTE, OP_CHK, OP_LEN, OP_CAP} dir_op_e;
  typedef struct packed {
    dir_op_e     op;
    logic [23:0] val;
    hcr_status_e want;
    logic [2:0]  lsize;
  } dir_row_t;

  localparam int unsigned N_DIR = 40;

  dir_row_t dir_tab [N_DIR] = '{
    // record at reset settings: 23 bytes, length size byte 0xff, no arrays
    '{OP_BYTE, 24'h00, ST_OK, 3'd0}, '{OP_BYTE, 24'h00, ST_OK, 3'd0},
    '{OP_BYTE, 24'h02, ST_OK, 3'd0}, '{OP_BYTE, 24'hff, ST_OK, 3'd0},
    '{OP_BYTE, 24'h55, ST_OK, 3'd0}, '{OP_BYTE, 24'haa, ST_OK, 3'd0},
    '{OP_BYTE, 24'h01, ST_OK, 3'd0}, '{OP_BYTE, 24'h80, ST_OK, 3'd0},
    '{OP_BYTE, 24'h7f, ST_OK, 3'd0}, '{OP_BYTE, 24'hfe, ST_OK, 3'd0},
    '{OP_BYTE, 24'h00, ST_OK, 3'd0}, '{OP_BYTE, 24'hff, ST_OK, 3'd0},
    '{OP_BYTE, 24'h33, ST_OK, 3'd0}, '{OP_BYTE, 24'hcc, ST_OK, 3'd0},
    '{OP_BYTE, 24'h0f, ST_OK, 3'd0}, '{OP_BYTE, 24'hf0, ST_OK, 3'd0},
    '{OP_BYTE, 24'h10, ST_OK, 3'd0}, '{OP_BYTE, 24'h20, ST_OK, 3'd0},
    '{OP_BYTE, 24'h40, ST_OK, 3'd0}, '{OP_BYTE, 24'h08, ST_OK, 3'd0},
    '{OP_BYTE, 24'h04, ST_OK, 3'd0}, '{OP_BYTE, 24'hff, ST_OK, 3'd0},
    '{OP_CHK,  24'h00, ST_OK, 3'd4},
    // one-byte records are too short
    '{OP_LEN,  24'h01, ST_OK, 3'd0},
    '{OP_CHK,  24'h00, ST_FORMAT, 3'd0}, '{OP_CHK, 24'hff, ST_FORMAT, 3'd0},
    // three bytes is still too short, the rest is absorbed
    '{OP_LEN,  24'h03, ST_OK, 3'd0},
    '{OP_CHK,  24'h80, ST_FORMAT, 3'd0},
    '{OP_BYTE, 24'h00, ST_OK, 3'd0}, '{OP_BYTE, 24'hff, ST_OK, 3'd0},
    // already in start-code form: 00 00 01
    '{OP_LEN,  24'h04, ST_OK, 3'd0},
    '{OP_BYTE, 24'h00, ST_OK, 3'd0}, '{OP_BYTE, 24'h00, ST_OK, 3'd0},
    '{OP_CHK,  24'h01, ST_FORMAT, 3'd0}, '{OP_BYTE, 24'hff, ST_OK, 3'd0},
    // 00 00 02 is no start code, so the short header is reported
    '{OP_BYTE, 24'h00, ST_OK, 3'd0}, '{OP_BYTE, 24'h00, ST_OK, 3'd0},
    '{OP_CHK,  24'h02, ST_TRUNC, 3'd0}, '{OP_BYTE, 24'h01, ST_OK, 3'd0},
    '{OP_CAP,  24'hffffff, ST_OK, 3'd0}
  };

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  hcr_cfg_e    cfg_idx = CFG_INPUT_LENGTH;
  logic [23:0] cfg_wdata = 24'd0;
  logic        s_tvalid = 1'b0;
  logic [7:0]  s_tdata = 8'd0;
  logic        m_tready = 1'b0;
  logic        s_tready;
  logic        m_tvalid;
  logic [39:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  hevc_config_record_to_annexb_top u_top (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_wdata_i     (cfg_wdata),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),    // [7:0] data_byte
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    // [7:0] out_byte, [10:8] status, [34:11] total_out, [37:35] length_size
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),    // [0] kind
    .m_axis_tlast_o  (m_tlast)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  out_item_t   exp_q [$];
  out_item_t   head_exp;
  logic [7:0]  rec_bytes [$];
  int unsigned err_cnt = 0;
  int unsigned n_results = 0;
  int unsigned n_sent = 0;
  int unsigned rec_no = 0;
  bit          calm = 1'b0;

  // parser copy: settings and record state
  logic [23:0] rec_len, out_cap;
  hcr_phase_e  ph;
  logic [23:0] pos, out_cnt;
  logic [7:0]  arr_left, hi_byte;
  logic [15:0] nal_left, nal_rem;
  logic [1:0]  zero_flags;
  logic [2:0]  len_size;

  function automatic void clear_parser();
    ph         = PH_HEAD;
    pos        = 24'd0;
    arr_left   = 8'd0;
    nal_left   = 16'd0;
    hi_byte    = 8'd0;
    nal_rem    = 16'd0;
    out_cnt    = 24'd0;
    zero_flags = 2'b00;
    len_size   = 3'd0;
  endfunction

  function automatic void push_expected(logic kind, logic [7:0] b, hcr_status_e st);
    out_item_t r;
    r.kind   = kind;
    r.obyte  = b;
    r.status = st;
    r.total  = out_cnt;
    r.lsize  = len_size;
    r.last   = 1'b0;
    exp_q.push_back(r);
  endfunction

  function automatic void close_record(hcr_status_e st);
    push_expected(KIND_DONE, 8'h00, st);
    ph = PH_ABSORB;
  endfunction

  function automatic void emit_stream_byte(logic [7:0] b);
    out_cnt = out_cnt + 24'd1;
    push_expected(KIND_BYTE, b, ST_OK);
  endfunction

  // bytes of the record still to come after the current one
  function automatic int unsigned bytes_after();
    int unsigned nxt;
    nxt = 32'(pos) + 32'd1;
    return (nxt <= 32'(rec_len)) ? 32'(rec_len) - nxt : 32'd0;
  endfunction

  function automatic void begin_array();
    if (arr_left == 8'd0) begin
      close_record(ST_OK);
    end else if (bytes_after() < 32'd3) begin
      close_record(ST_TRUNC);
    end else begin
      arr_left = arr_left - 8'd1;
      ph = PH_ATYPE;
    end
  endfunction

  function automatic void begin_nal();
    if (nal_left == 16'd0) begin
      begin_array();
    end else if (bytes_after() < 32'd2) begin
      close_record(ST_TRUNC);
    end else begin
      nal_left = nal_left - 16'd1;
      ph = PH_NLEN_HI;
    end
  endfunction

  function automatic void header_byte(logic [7:0] b);
    if (pos == 24'd0) begin
      if (b == 8'd0) zero_flags[0] = 1'b1;
      if (rec_len <= MIN_LEN) close_record(ST_FORMAT);
    end else if (pos == 24'd1) begin
      if (b == 8'd0) zero_flags[1] = 1'b1;
    end else if (pos == 24'd2) begin
      if (zero_flags == 2'b11 && b <= SC_ONE) close_record(ST_FORMAT);
      else if (rec_len < HDR_LEN) close_record(ST_TRUNC);
    end else if (32'(pos) == HDR_LSIZE_POS) begin
      len_size = {1'b0, b[1:0] & LSIZE_MASK} + 3'd1;
    end else if (32'(pos) == HDR_NARR_POS) begin
      arr_left = b;
      begin_array();
    end
  endfunction

  // advance the parser copy by one record byte, queue its results, return their number
  function automatic int convert_byte(logic [7:0] b);
    int unsigned n0;
    int unsigned nlen;
    n0 = exp_q.size();
    case (ph)
      PH_HEAD: header_byte(b);
      PH_ATYPE: ph = PH_CNT_HI;
      PH_CNT_HI: begin
        hi_byte = b;
        ph = PH_CNT_LO;
      end
      PH_CNT_LO: begin
        nal_left = {hi_byte, b};
        begin_nal();
      end
      PH_NLEN_HI: begin
        hi_byte = b;
        ph = PH_NLEN_LO;
      end
      PH_NLEN_LO: begin
        nlen = {16'd0, hi_byte, b};
        if (nlen > bytes_after()) begin
          close_record(ST_SIZE);
        end else if (32'(out_cnt) + 32'd4 + nlen > 32'(out_cap)) begin
          close_record(ST_FULL);
        end else begin
          repeat (3) emit_stream_byte(SC_ZERO);
          emit_stream_byte(SC_ONE);
          nal_rem = nlen[15:0];
          if (nal_rem == 16'd0) begin_nal();
          else ph = PH_NDATA;
        end
      end
      PH_NDATA: begin
        emit_stream_byte(b);
        if (nal_rem != 16'd0) nal_rem = nal_rem - 16'd1;
        if (nal_rem == 16'd0) begin_nal();
      end
      default: ph = PH_ABSORB;
    endcase
    // end of record, also when the length was lowered under the position
    if (32'(pos) + 32'd1 >= 32'(rec_len)) begin
      if (ph != PH_ABSORB) close_record(ST_TRUNC);
      clear_parser();
    end else begin
      pos = pos + 24'd1;
    end
    if (exp_q.size() > n0) exp_q[exp_q.size() - 1].last = 1'b1;
    return exp_q.size() - n0;
  endfunction

  task automatic report_mismatch(string msg);
    if (err_cnt < MAX_REPORTS) $display("%0t result %0d: %s", $time, n_results, msg);
    err_cnt++;
  endtask

  task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
  endtask

  // master side: random stalls outside the calm stretch
  always @(posedge clk) begin
    m_tready <= calm || ($urandom_range(99) >= 6);
  end

  // compare each output transfer with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) begin
      if (exp_q.size() == 0) begin
        report_mismatch($sformatf("unexpected transfer tdata %h tuser %b", m_tdata, m_tuser));
      end else begin
        head_exp = exp_q.pop_front();
        check_field("kind", 32'(m_tuser), 32'(head_exp.kind));
        check_field("out_byte", 32'(m_tdata[7:0]), 32'(head_exp.obyte));
        check_field("status", 32'(m_tdata[10:8]), 32'(head_exp.status));
        check_field("total_out", 32'(m_tdata[34:11]), 32'(head_exp.total));
        check_field("length_size", 32'(m_tdata[37:35]), 32'(head_exp.lsize));
        check_field("last", 32'(m_tlast), 32'(head_exp.last));
      end
      n_results++;
    end
  end

  // one input transfer, with random gaps in front
  task automatic send_byte(logic [7:0] b, output int n_new);
    while (!calm && $urandom_range(99) < 6) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n_sent++;
    n_new = convert_byte(b);
  endtask

  // drop valid, wait for all results, then let the pipeline drain
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_reg(hcr_cfg_e idx, logic [23:0] val);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    if (idx == CFG_INPUT_LENGTH) rec_len = val;
    else out_cap = val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // well-formed record with random content, some counts and lengths out of range
  function automatic void build_record();
    int unsigned n_arr, n_nal, nal_len;
    rec_bytes.delete();
    repeat (HDR_LSIZE_POS) rec_bytes.push_back(8'($urandom));
    rec_bytes.push_back(8'($urandom));
    n_arr = ($urandom_range(99) < 8) ? $urandom_range(4, 255) : $urandom_range(0, 3);
    rec_bytes.push_back(8'(n_arr));
    for (int a = 0; a < 3 && a < int'(n_arr); a++) begin
      n_nal = ($urandom_range(99) < 8) ? $urandom_range(4, 65535) : $urandom_range(0, 3);
      rec_bytes.push_back(8'($urandom));
      rec_bytes.push_back(8'(n_nal >> 8));
      rec_bytes.push_back(8'(n_nal));
      for (int j = 0; j < 3 && j < int'(n_nal); j++) begin
        nal_len = ($urandom_range(99) < 6) ? $urandom_range(9, 65535) : $urandom_range(0, 8);
        rec_bytes.push_back(8'(nal_len >> 8));
        rec_bytes.push_back(8'(nal_len));
        repeat ((nal_len > 8) ? 2 : nal_len) rec_bytes.push_back(8'($urandom));
      end
    end
  endfunction

  // capacity: unlimited, tight, or none
  task automatic pick_capacity();
    case (rec_no % 4)
      0, 1: set_reg(CFG_OUTPUT_CAPACITY, 24'hffffff);
      2: set_reg(CFG_OUTPUT_CAPACITY, 24'($urandom_range(0, 60)));
      default: set_reg(CFG_OUTPUT_CAPACITY, 24'd0);
    endcase
  endtask

  // full record, cut short at times, padded with trailing bytes otherwise
  task automatic plain_record();
    int unsigned len;
    int n;
    build_record();
    pick_capacity();
    if ($urandom_range(99) < 20) begin
      len = $urandom_range(32'(HDR_LEN), rec_bytes.size());
    end else begin
      len = rec_bytes.size() + $urandom_range(0, 3);
      while (rec_bytes.size() < len) rec_bytes.push_back(8'($urandom));
    end
    set_reg(CFG_INPUT_LENGTH, 24'(len));
    for (int i = 0; i < int'(len); i++) send_byte(rec_bytes[i], n);
  endtask

  // short records, often starting like a start code
  task automatic noise_record();
    int unsigned len;
    bit sc_head;
    logic [7:0] b;
    int n;
    len = $urandom_range(1, 22);
    sc_head = ($urandom_range(99) < 40);
    set_reg(CFG_INPUT_LENGTH, 24'(len));
    for (int i = 0; i < int'(len); i++) begin
      b = 8'($urandom);
      if (sc_head && i < 2) b = SC_ZERO;
      else if (sc_head && i == 2) b = 8'($urandom_range(0, 1));
      send_byte(b, n);
    end
  endtask

  // longest length, then lowered while the record runs so that the next byte ends it
  task automatic relength_record();
    int unsigned k;
    int n;
    build_record();
    pick_capacity();
    set_reg(CFG_INPUT_LENGTH, 24'hffffff);
    k = $urandom_range(1, rec_bytes.size());
    for (int i = 0; i < int'(k); i++) send_byte(rec_bytes[i], n);
    set_reg(CFG_INPUT_LENGTH, 24'($urandom_range(1, k + 1)));
    send_byte(8'($urandom), n);
  endtask

  // main sequence
  initial begin
    int n;
    rec_len = HDR_LEN;
    out_cap = 24'd0;
    clear_parser();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    foreach (dir_tab[i]) begin
      case (dir_tab[i].op)
        OP_LEN: set_reg(CFG_INPUT_LENGTH, dir_tab[i].val);
        OP_CAP: set_reg(CFG_OUTPUT_CAPACITY, dir_tab[i].val);
        default: begin
          send_byte(dir_tab[i].val[7:0], n);
          if (dir_tab[i].op == OP_CHK) begin
            repeat (n) void'(exp_q.pop_back());
            exp_q.push_back('{KIND_DONE, 8'h00, dir_tab[i].want, 24'd0,
                              dir_tab[i].lsize, 1'b1});
          end
        end
      endcase
    end

    // random records until the input budget is spent
    while (n_sent < REC_ITEMS) begin
      calm = (n_sent >= 120 && n_sent < 200);
      case (rec_no % 8)
        3: noise_record();
        6: relength_record();
        default: plain_record();
      endcase
      rec_no++;
    end
    calm = 1'b0;

    wait_idle();
    if (err_cnt == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hcr_pkg.sv
rtl/hcr_front.sv
rtl/hcr_queue.sv
rtl/hcr_back.sv
rtl/hevc_config_record_to_annexb_top.sv
tb/tb_hevc_config_record_to_annexb_top.sv
